// File: design/swma_pkg.sv
package swma_pkg;

    // Fixed field widths of the channels and the configuration register.
    localparam int SAMPLE_W  = 16;
    localparam int LEN_W     = 7;
    localparam int SUM_OUT_W = 22;
    localparam int AVG_W     = 24;
    localparam int FRAC_BITS = 8;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_UPDATE   = 5'b00010,
        S_DIV_LOAD = 5'b00100,
        S_DIV      = 5'b01000,
        S_EMIT     = 5'b10000
    } swma_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic update;
        logic div_load;
        logic div_step;
        logic emit;
    } swma_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic last;
        logic div_done;
        logic out_free;
    } swma_status_t;

endpackage

// File: design/swma_sample_if.sv
interface swma_sample_if;
    import swma_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink (input valid, input sample, input last_sample, output ready);
endinterface

// File: design/swma_result_if.sv
interface swma_result_if;
    import swma_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [SUM_OUT_W-1:0] max_window_sum;
    logic [AVG_W-1:0]     max_average;
    logic                 window_seen;

    modport source (output valid, output max_window_sum, output max_average,
                    output window_seen, input ready);
    modport sink (input valid, input max_window_sum, input max_average,
                  input window_seen, output ready);
endinterface

// File: design/swma_ctrl.sv
module swma_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  swma_pkg::swma_status_t status,
    output swma_pkg::swma_cmd_t    cmd
);
    import swma_pkg::*;

    swma_state_t state_reg;
    swma_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = status.last ? S_DIV_LOAD : S_IDLE;
            end
            S_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_EMIT:
            begin
                // The result register must be free before the stream state is dropped.
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/swma_datapath.sv
module swma_datapath #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [swma_pkg::LEN_W-1:0]      cfg_data,
    input  logic [swma_pkg::SAMPLE_W-1:0]   sample,
    input  logic                            last_sample,
    input  swma_pkg::swma_cmd_t             cmd,
    output swma_pkg::swma_status_t          status,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [swma_pkg::SUM_OUT_W-1:0]  max_window_sum,
    output logic [swma_pkg::AVG_W-1:0]      max_average,
    output logic                            window_seen
);
    import swma_pkg::*;

    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int IDX_W = PTR_W + 1;
    localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int DIV_W = SUM_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [SAMPLE_BITS-1:0]        ring_mem [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0]        sample_raw;
    logic                          last_reg;

    logic [LEN_W-1:0]              wlen_reg;
    logic [LEN_W-1:0]              len;
    logic [PTR_W-1:0]              ptr_reg;
    logic [PTR_W-1:0]              ptr_next;
    logic [LEN_W-1:0]              fill_reg;
    logic signed [SUM_W-1:0]       run_reg;
    logic signed [SUM_W-1:0]       best_reg;
    logic signed [SUM_W-1:0]       run_next;
    logic                          full;

    logic [IDX_W-1:0]              idx_sum;
    logic [PTR_W-1:0]              old_idx;

    logic [DIV_W-1:0]              div_q_reg;
    logic [LEN_W-1:0]              rem_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          neg_reg;
    logic [SUM_W-1:0]              best_mag;
    logic [LEN_W:0]                trial;
    logic                          trial_ge;
    logic signed [DIV_W:0]         avg_s;

    logic                          out_valid_reg;
    logic [SUM_OUT_W-1:0]          out_sum_reg;
    logic [AVG_W-1:0]              out_avg_reg;
    logic                          out_seen_reg;

    // Samples narrower than the field use its low bits; wider ones see it zero-extended.
    if (SAMPLE_BITS <= SAMPLE_W)
    begin : g_narrow
        assign sample_raw = sample[SAMPLE_BITS-1:0];
    end
    else
    begin : g_wide
        assign sample_raw = {{(SAMPLE_BITS - SAMPLE_W){1'b0}}, sample};
    end

    always_comb
    begin
        if (wlen_reg == '0)
        begin
            len = LEN_W'(1);
        end
        else if (int'(wlen_reg) > MAX_WINDOW)
        begin
            len = LEN_W'(MAX_WINDOW);
        end
        else
        begin
            len = wlen_reg;
        end
    end

    assign full = (fill_reg >= len);

    // Slot of the sample that leaves the window: ptr - len, modulo the ring depth.
    always_comb
    begin
        idx_sum = {1'b0, ptr_reg} + IDX_W'(MAX_WINDOW) - IDX_W'(len);
        if (idx_sum >= IDX_W'(MAX_WINDOW))
        begin
            old_idx = PTR_W'(idx_sum - IDX_W'(MAX_WINDOW));
        end
        else
        begin
            old_idx = idx_sum[PTR_W-1:0];
        end
    end

    assign ptr_next = (ptr_reg == PTR_W'(MAX_WINDOW - 1)) ? '0 : ptr_reg + 1'b1;

    always_comb
    begin
        if (full)
        begin
            run_next = run_reg + SUM_W'(sample_reg) - SUM_W'(rd_data_reg);
        end
        else
        begin
            run_next = run_reg + SUM_W'(sample_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rd_data_reg <= ring_mem[old_idx];
            sample_reg  <= sample_raw;
            last_reg    <= last_sample;
        end
        if (cmd.update)
        begin
            ring_mem[ptr_reg] <= sample_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= LEN_W'(1);
            ptr_reg  <= '0;
            fill_reg <= '0;
            run_reg  <= '0;
            best_reg <= '0;
        end
        else if (cfg_write)
        begin
            wlen_reg <= cfg_data;
            ptr_reg  <= '0;
            fill_reg <= '0;
            run_reg  <= '0;
            best_reg <= '0;
        end
        else if (cmd.update)
        begin
            run_reg <= run_next;
            ptr_reg <= ptr_next;
            if (full)
            begin
                if (run_next > best_reg)
                begin
                    best_reg <= run_next;
                end
            end
            else
            begin
                fill_reg <= fill_reg + 1'b1;
                // The first full window seeds the maximum.
                if (fill_reg + 1'b1 == len)
                begin
                    best_reg <= run_next;
                end
            end
        end
        else if (cmd.emit)
        begin
            ptr_reg  <= '0;
            fill_reg <= '0;
            run_reg  <= '0;
            best_reg <= '0;
        end
    end

    // Restoring division of |best| * 256 by the window length, one quotient bit a cycle.
    assign best_mag = best_reg[SUM_W-1] ? (~best_reg + 1'b1) : best_reg;
    assign trial    = {rem_reg, div_q_reg[DIV_W-1]};
    assign trial_ge = (trial >= {1'b0, len});

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            div_q_reg <= {best_mag, {FRAC_BITS{1'b0}}};
            rem_reg   <= '0;
            neg_reg   <= best_reg[SUM_W-1];
        end
        else if (cmd.div_step)
        begin
            div_q_reg <= {div_q_reg[DIV_W-2:0], trial_ge};
            rem_reg   <= trial_ge ? LEN_W'(trial - {1'b0, len}) : trial[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_load)
        begin
            cnt_reg <= CNT_W'(DIV_W);
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign avg_s = neg_reg ? (~{1'b0, div_q_reg} + 1'b1) : {1'b0, div_q_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_seen_reg <= full;
            out_sum_reg  <= full ? SUM_OUT_W'(best_reg) : '0;
            out_avg_reg  <= full ? AVG_W'(avg_s) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.last     = last_reg;
    assign status.div_done = (cnt_reg == '0);
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign max_window_sum = out_sum_reg;
    assign max_average    = out_avg_reg;
    assign window_seen    = out_seen_reg;

endmodule

// File: design/sliding_window_max_average_unit.sv
// Each sample item is accepted, with the leaving sample read from the ring memory, and then
// the ring, running sum and maximum are updated; a new sample is accepted only after that.
// After an item marked last, the bit-serial divider is loaded and run, and the result item
// is loaded once any earlier result item has left the output.
// Asynchronous active-low reset sets the window length to 1 and clears the stream state.
module sliding_window_max_average_unit #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [swma_pkg::LEN_W-1:0] cfg_data,
    swma_sample_if.sink                sample_ch,
    swma_result_if.source              result_ch
);
    import swma_pkg::*;

    swma_cmd_t    cmd;
    swma_status_t status;
    logic         in_ready;

    assign sample_ch.ready = in_ready;

    swma_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    swma_datapath #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .sample         (sample_ch.sample),
        .last_sample    (sample_ch.last_sample),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (result_ch.valid),
        .out_ready      (result_ch.ready),
        .max_window_sum (result_ch.max_window_sum),
        .max_average    (result_ch.max_average),
        .window_seen    (result_ch.window_seen)
    );

endmodule

// File: design/swma_checker.sv
module swma_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cfg_write,
    input logic                           r_valid,
    input logic                           r_ready,
    input logic [swma_pkg::SUM_OUT_W-1:0] r_sum,
    input logic [swma_pkg::AVG_W-1:0]     r_avg,
    input logic                           r_seen
);
    import swma_pkg::*;

    // A result item waiting for the sink keeps its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> r_valid && $stable(r_sum) && $stable(r_avg)
            && $stable(r_seen))
        else $error("result item changed while stalled");

    // A stream too short for a full window reports zeros.
    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_seen |-> r_sum == '0 && r_avg == '0)
        else $error("short stream result is not zero");

    // The average carries the sign of the sum and is zero only with it.
    a_avg_sign: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && r_seen |-> r_sum[SUM_OUT_W-1] == r_avg[AVG_W-1]
            && ((r_sum == '0) == (r_avg == '0)))
        else $error("average disagrees with window sum");

    // Users must write the configuration only while idle; the block does not enforce it.
    a_cfg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> !$rose(r_valid))
        else $error("result item appeared right after a configuration write");

endmodule

bind sliding_window_max_average_unit swma_checker u_swma_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_write (cfg_write),
    .r_valid   (result_ch.valid),
    .r_ready   (result_ch.ready),
    .r_sum     (result_ch.max_window_sum),
    .r_avg     (result_ch.max_average),
    .r_seen    (result_ch.window_seen)
);
